/* rtl/bprd_pkg.sv */
package bprd_pkg;

    // Sizing of the per-button state table.
    localparam int NUM_CONTROLLERS = 4;
    localparam int NUM_BUTTONS     = 16;
    localparam int SLOT_COUNT      = NUM_CONTROLLERS * NUM_BUTTONS;
    localparam int SLOT_W          = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Field widths.
    localparam int CTRL_W   = 2;
    localparam int BTN_W    = 4;
    localparam int AMT_W    = 8;
    localparam int TIME_W   = 48;
    localparam int DELAY_W  = 24;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 16;

    // Reset values of the configuration registers.
    localparam logic [AMT_W-1:0]   THRESHOLD_RST     = AMT_W'(30);
    localparam logic [DELAY_W-1:0] INIT_DELAY_RST    = '0;
    localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = '0;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_THRESHOLD      = 2'd0,
        CFG_INITIAL_REPEAT_DELAY = 2'd1,
        CFG_REPEAT_DELAY         = 2'd2
    } cfg_idx_t;

    // Event kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_PRESSED  = 2'd0,
        KIND_RELEASED = 2'd1,
        KIND_REPEAT   = 2'd2
    } kind_t;

    // One table entry per controller and button.
    typedef struct packed {
        logic [TIME_W-1:0] due;
        logic [AMT_W-1:0]  prev;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Configuration as seen by the update logic.
    typedef struct packed {
        logic [AMT_W-1:0]   threshold;
        logic [DELAY_W-1:0] init_delay;
        logic [DELAY_W-1:0] repeat_delay;
    } cfg_t;

    // Decision of the update logic for one sample.
    typedef struct packed {
        logic   fire;
        kind_t  kind;
        entry_t wr_entry;
    } decision_t;

    // True when the sample addresses an existing controller and button.
    function automatic logic in_range(input logic [CTRL_W-1:0] ctrl,
                                      input logic [BTN_W-1:0] btn);
        return (int'(ctrl) < NUM_CONTROLLERS) && (int'(btn) < NUM_BUTTONS);
    endfunction

    // Table address of a controller and button.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [CTRL_W-1:0] ctrl,
                                                  input logic [BTN_W-1:0] btn);
        return SLOT_W'(int'(ctrl) * NUM_BUTTONS + int'(btn));
    endfunction

endpackage

/* rtl/button_press_repeat_detector_top.sv */
// Button press and auto-repeat detector. Each input transaction is one sample of one
// button; the block keeps the last amount and the next repeat time of every button in
// a small table memory and emits a pressed, released or repeat event when one is due,
// or nothing. It takes one sample every clock cycle unless held off: the table is read on
// the accepting edge and written back when the sample leaves the update stage, and a
// write-back forwarding register covers back-to-back samples of the same button. An event
// is loaded into the output register when its sample leaves the update stage. Input is
// held off only when a sample that produces an event finds the output register full and
// not being drained. The table starts cleared after reset with no clearing pass. The user
// must make configuration writes only while idle; the block itself does not enforce it.
module button_press_repeat_detector_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_wr_en,
    input  logic [bprd_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [bprd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Sample input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] controller_index, [5:2] button_index, [13:6] amount, [61:14] current_time
    input  logic [bprd_pkg::S_TDATA_W-1:0]      s_tdata,
    // Event output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] event_controller, [5:2] event_button, [13:6] event_amount
    output logic [bprd_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] event_kind
    output logic [bprd_pkg::KIND_W-1:0]         m_tuser
);
    import bprd_pkg::*;

    localparam int BTN_LO  = CTRL_W;
    localparam int AMT_LO  = BTN_LO + BTN_W;
    localparam int TIME_LO = AMT_LO + AMT_W;
    localparam int OUT_W   = CTRL_W + BTN_W + AMT_W;

    // Configuration registers.
    cfg_t cfg_reg;

    // Sample fields.
    logic [CTRL_W-1:0] in_ctrl;
    logic [BTN_W-1:0]  in_btn;
    logic [AMT_W-1:0]  in_amt;
    logic [TIME_W-1:0] in_time;

    // Update stage.
    logic              st1_valid_reg;
    logic              st1_valid_next;
    logic              st1_inrange_reg;
    logic [CTRL_W-1:0] st1_ctrl_reg;
    logic [BTN_W-1:0]  st1_btn_reg;
    logic [AMT_W-1:0]  st1_amt_reg;
    logic [TIME_W-1:0] st1_time_reg;
    logic [SLOT_W-1:0] st1_slot_reg;

    // Output register.
    logic              m_valid_reg;
    logic              m_valid_next;
    kind_t             m_kind_reg;
    logic [CTRL_W-1:0] m_ctrl_reg;
    logic [BTN_W-1:0]  m_btn_reg;
    logic [AMT_W-1:0]  m_amt_reg;

    logic              in_acc;
    logic              out_free;
    logic              st1_adv;
    logic              wr_en;
    entry_t            rd_entry;
    decision_t         dec;

    assign in_ctrl = s_tdata[CTRL_W-1:0];
    assign in_btn  = s_tdata[AMT_LO-1:BTN_LO];
    assign in_amt  = s_tdata[TIME_LO-1:AMT_LO];
    assign in_time = s_tdata[TIME_LO+TIME_W-1:TIME_LO];

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold    <= THRESHOLD_RST;
            cfg_reg.init_delay   <= INIT_DELAY_RST;
            cfg_reg.repeat_delay <= REPEAT_DELAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_PRESS_THRESHOLD:      cfg_reg.threshold    <= cfg_wdata[AMT_W-1:0];
                CFG_INITIAL_REPEAT_DELAY: cfg_reg.init_delay   <= cfg_wdata[DELAY_W-1:0];
                CFG_REPEAT_DELAY:         cfg_reg.repeat_delay <= cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: the update stage moves on unless its event meets a full output.
    assign out_free = !m_valid_reg || m_tready;
    assign st1_adv  = st1_valid_reg && (!dec.fire || out_free);
    assign s_tready = !st1_valid_reg || st1_adv;
    assign in_acc   = s_tvalid && s_tready;
    assign wr_en    = st1_adv && st1_inrange_reg;

    assign st1_valid_next = in_acc || (st1_valid_reg && !st1_adv);

    always_comb begin
        if (st1_adv && dec.fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Capture the sample while its table entry is being read.
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            st1_inrange_reg <= in_range(in_ctrl, in_btn);
            st1_ctrl_reg    <= in_ctrl;
            st1_btn_reg     <= in_btn;
            st1_amt_reg     <= in_amt;
            st1_time_reg    <= in_time;
            st1_slot_reg    <= slot_of(in_ctrl, in_btn);
        end
    end

    bprd_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (in_acc),
        .rd_slot  (slot_of(in_ctrl, in_btn)),
        .wr_en    (wr_en),
        .wr_slot  (st1_slot_reg),
        .wr_entry (dec.wr_entry),
        .rd_entry (rd_entry)
    );

    bprd_event u_event (
        .cfg          (cfg_reg),
        .active       (st1_inrange_reg),
        .amount       (st1_amt_reg),
        .current_time (st1_time_reg),
        .entry        (rd_entry),
        .dec          (dec)
    );

    // Load the output register with a new event.
    always_ff @(posedge aclk) begin
        if (st1_adv && dec.fire) begin
            m_kind_reg <= dec.kind;
            m_ctrl_reg <= st1_ctrl_reg;
            m_btn_reg  <= st1_btn_reg;
            m_amt_reg  <= st1_amt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, m_amt_reg, m_btn_reg, m_ctrl_reg};

    // A stalled update stage keeps its sample.
    a_st1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_adv) |=> (st1_valid_reg && $stable(st1_slot_reg)))
        else $error("update stage lost its sample while stalled");

    // An event leaving the update stage shows up in the output register.
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_adv && dec.fire) |=> (m_valid_reg && (m_tuser == $past(dec.kind))))
        else $error("event not loaded into the output register");

    // A repeat needs a held button.
    a_repeat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && dec.fire && (dec.kind == KIND_REPEAT))
            |-> (st1_amt_reg > cfg_reg.threshold))
        else $error("repeat event for a button that is not pressed");

    // A sample for a missing controller or button changes nothing.
    a_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_inrange_reg) |-> (!dec.fire && !wr_en))
        else $error("out of range sample produced an event or a write");

endmodule

/* rtl/bprd_ram.sv */
module bprd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port; a read at the written address returns old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/bprd_store.sv */
module bprd_store (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    rd_en,
    input  logic [bprd_pkg::SLOT_W-1:0] rd_slot,
    input  logic                    wr_en,
    input  logic [bprd_pkg::SLOT_W-1:0] wr_slot,
    input  bprd_pkg::entry_t        wr_entry,
    output bprd_pkg::entry_t        rd_entry
);
    import bprd_pkg::*;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic [SLOT_W-1:0]     rd_slot_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic                  fwd_valid_reg;
    logic [SLOT_W-1:0]     fwd_slot_reg;
    entry_t                fwd_entry_reg;

    bprd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_slot),
        .wdata (wr_entry),
        .re    (rd_en),
        .raddr (rd_slot),
        .rdata (ram_rdata)
    );

    // Remember which slot the pending read data belongs to.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_slot_reg <= rd_slot;
        end
    end

    // Written-once flags stand in for clearing the table at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_slot] <= 1'b1;
        end
    end

    // Keep the latest write; it covers a read issued on the same edge as that write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (wr_en) begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            fwd_slot_reg  <= wr_slot;
            fwd_entry_reg <= wr_entry;
        end
    end

    // Forwarded data first, then stored data, then the reset value.
    always_comb begin
        if (fwd_valid_reg && (fwd_slot_reg == rd_slot_reg)) begin
            rd_entry = fwd_entry_reg;
        end else if (valid_reg[rd_slot_reg]) begin
            rd_entry = entry_t'(ram_rdata);
        end else begin
            rd_entry = '0;
        end
    end

endmodule

/* rtl/bprd_event.sv */
module bprd_event (
    input  bprd_pkg::cfg_t                     cfg,
    input  logic                               active,
    input  logic [bprd_pkg::AMT_W-1:0]         amount,
    input  logic [bprd_pkg::TIME_W-1:0]        current_time,
    input  bprd_pkg::entry_t                   entry,
    output bprd_pkg::decision_t                dec
);
    import bprd_pkg::*;

    logic               pressed;
    logic               was_pressed;
    logic               due_now;
    logic [DELAY_W-1:0] delay;
    logic [TIME_W:0]    due_sum;
    logic [TIME_W-1:0]  due_next;

    assign pressed     = amount > cfg.threshold;
    assign was_pressed = entry.prev > cfg.threshold;
    assign due_now     = entry.due <= current_time;

    // A press schedules the first repeat, a repeat the next one.
    assign delay    = (pressed != was_pressed) ? cfg.init_delay : cfg.repeat_delay;
    assign due_sum  = {1'b0, current_time} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay};
    assign due_next = due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];

    // Edge detection against the stored amount, then the repeat timer.
    always_comb begin
        dec.fire          = 1'b0;
        dec.kind          = KIND_PRESSED;
        dec.wr_entry.prev = amount;
        dec.wr_entry.due  = entry.due;
        if (active) begin
            if (pressed != was_pressed) begin
                dec.fire = 1'b1;
                if (pressed) begin
                    dec.kind         = KIND_PRESSED;
                    dec.wr_entry.due = due_next;
                end else begin
                    dec.kind = KIND_RELEASED;
                end
            end else if (pressed && due_now) begin
                dec.fire         = 1'b1;
                dec.kind         = KIND_REPEAT;
                dec.wr_entry.due = due_next;
            end
        end
    end

endmodule

/* dv/bprd_event_checker.sv */
module bprd_event_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bprd_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [bprd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bprd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bprd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [bprd_pkg::KIND_W-1:0]     m_tuser,
    output int                              mismatch_count,
    output int                              pending_events
);
    timeunit 1ns;
    timeprecision 1ps;
    import bprd_pkg::*;

    // One button event as it should leave the block.
    typedef struct packed {
        kind_t             kind;
        logic [CTRL_W-1:0] ctrl;
        logic [BTN_W-1:0]  btn;
        logic [AMT_W-1:0]  amt;
    } button_event_t;

    // Mirror of the per-button table and of the configuration registers.
    logic [AMT_W-1:0]   last_amount [SLOT_COUNT];
    logic [TIME_W-1:0]  next_repeat [SLOT_COUNT];
    logic [AMT_W-1:0]   threshold;
    logic [DELAY_W-1:0] first_delay;
    logic [DELAY_W-1:0] later_delay;

    button_event_t event_queue [$];

    // Due time after a delay, clamped to the largest tick count.
    function automatic logic [TIME_W-1:0] saturating_due(input logic [TIME_W-1:0]  now,
                                                        input logic [DELAY_W-1:0] dly);
        logic [TIME_W:0] sum;
        sum = {1'b0, now} + TIME_W'(dly);
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

    // Updates the mirrored table for one sample; returns 1 when an event is due.
    function automatic bit track_button(input logic [CTRL_W-1:0] ctrl,
                                        input logic [BTN_W-1:0]  btn,
                                        input logic [AMT_W-1:0]  amt,
                                        input logic [TIME_W-1:0] now,
                                        output button_event_t    ev);
        int slot;
        bit pressed;
        bit was_pressed;
        bit fire;
        fire = 1'b0;
        ev = '0;
        if (int'(ctrl) >= NUM_CONTROLLERS || int'(btn) >= NUM_BUTTONS)
            return 1'b0;
        slot = int'(ctrl) * NUM_BUTTONS + int'(btn);
        pressed = amt > threshold;
        was_pressed = last_amount[slot] > threshold;
        if (pressed != was_pressed) begin
            fire = 1'b1;
            if (pressed) begin
                ev.kind = KIND_PRESSED;
                next_repeat[slot] = saturating_due(now, first_delay);
            end else begin
                // A release leaves the scheduled repeat time alone.
                ev.kind = KIND_RELEASED;
            end
        end else if (pressed && next_repeat[slot] <= now) begin
            fire = 1'b1;
            ev.kind = KIND_REPEAT;
            next_repeat[slot] = saturating_due(now, later_delay);
        end
        last_amount[slot] = amt;
        ev.ctrl = ctrl;
        ev.btn = btn;
        ev.amt = amt;
        return fire;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want !== got) begin
            $display("%0t: event %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result transactions are checked before new samples are predicted, since an
    // event can never belong to a sample taken at the same edge.
    always @(posedge aclk) begin
        button_event_t got;
        button_event_t want;
        button_event_t ev;
        if (!aresetn) begin
            threshold = THRESHOLD_RST;
            first_delay = INIT_DELAY_RST;
            later_delay = REPEAT_DELAY_RST;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                last_amount[i] = '0;
                next_repeat[i] = '0;
            end
            event_queue.delete();
            mismatch_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tuser);
                got.ctrl = m_tdata[1:0];
                got.btn = m_tdata[5:2];
                got.amt = m_tdata[13:6];
                if (event_queue.size() == 0) begin
                    $display("%0t: unexpected event, expected none, actual %0d/%0d/%0d/%0d",
                             $time, got.kind, got.ctrl, got.btn, got.amt);
                    mismatch_count++;
                end else begin
                    want = event_queue.pop_front();
                    compare_field("kind", want.kind, got.kind);
                    compare_field("controller", want.ctrl, got.ctrl);
                    compare_field("button", want.btn, got.btn);
                    compare_field("amount", want.amt, got.amt);
                end
            end

            // Register writes; the spare index has no register behind it.
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_PRESS_THRESHOLD:      threshold = cfg_wdata[AMT_W-1:0];
                    CFG_INITIAL_REPEAT_DELAY: first_delay = cfg_wdata[DELAY_W-1:0];
                    CFG_REPEAT_DELAY:         later_delay = cfg_wdata[DELAY_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                if (track_button(s_tdata[1:0], s_tdata[5:2], s_tdata[13:6],
                                 s_tdata[61:14], ev))
                    event_queue.push_back(ev);
            end
        end
        pending_events <= event_queue.size();
    end

endmodule

/* dv/button_press_repeat_detector_top_tb.sv */
module button_press_repeat_detector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bprd_pkg::*;

    // Index with no register behind it; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam logic [TIME_W-1:0]    TIME_MAX      = {TIME_W{1'b1}};
    localparam int                   HOLD_CYCLES   = 300;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;

    int mismatch_count;
    int pending_events;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    always #5 aclk = ~aclk;

    button_press_repeat_detector_top dut (.*);

    bprd_event_checker checker_i (.*);

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn || hold_left > 0) begin
            m_tready <= 1'b0;
            if (hold_left > 0)
                hold_left--;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offers one button sample, with random idle cycles ahead of it.
    task automatic send_button_sample(input logic [CTRL_W-1:0] ctrl,
                                      input logic [BTN_W-1:0]  btn,
                                      input logic [AMT_W-1:0]  amt,
                                      input logic [TIME_W-1:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, now, amt, btn, ctrl};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits until every predicted event has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [AMT_W-1:0]   thr,
                                input logic [DELAY_W-1:0] first_dly,
                                input logic [DELAY_W-1:0] later_dly);
        wait_drained();
        write_reg(CFG_PRESS_THRESHOLD, CFG_DATA_W'(thr));
        write_reg(CFG_INITIAL_REPEAT_DELAY, first_dly);
        write_reg(CFG_REPEAT_DELAY, later_dly);
    endtask

    task automatic set_pacing(input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Mostly press-hold-release runs on a few buttons, the rest random noise.
    task automatic run_random_presses(input int count, input logic [TIME_W-1:0] base,
                                      input logic [AMT_W-1:0] thr);
        logic [CTRL_W-1:0] hot_ctrl [4];
        logic [BTN_W-1:0]  hot_btn [4];
        bit                held [4];
        logic [TIME_W-1:0] now;
        logic [CTRL_W-1:0] c;
        logic [BTN_W-1:0]  b;
        logic [AMT_W-1:0]  a;
        int                k;
        int                step;
        for (int i = 0; i < 4; i++) begin
            hot_ctrl[i] = CTRL_W'($urandom);
            hot_btn[i] = BTN_W'($urandom);
            held[i] = 1'b0;
        end
        now = base;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 80) begin
                k = $urandom_range(0, 3);
                if ($urandom_range(0, 99) < 15)
                    held[k] = !held[k];
                c = hot_ctrl[k];
                b = hot_btn[k];
                if (held[k])
                    a = (thr == 8'hFF) ? 8'hFF : AMT_W'($urandom_range(int'(thr) + 1, 255));
                else
                    a = AMT_W'($urandom_range(0, int'(thr)));
            end else begin
                c = CTRL_W'($urandom);
                b = BTN_W'($urandom);
                a = AMT_W'($urandom);
            end
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 4);
            now = (TIME_MAX - now < TIME_W'(step)) ? TIME_MAX : now + TIME_W'(step);
            send_button_sample(c, b, a, now);
        end
    endtask

    // Run ends on a timeout if the block stops making progress.
    initial begin
        #2_000_000;
        $display("button_press_repeat_detector_top_tb: done, errors");
        $finish;
    end

    initial begin
        logic [AMT_W-1:0]   thr;
        logic [DELAY_W-1:0] first_dly;
        logic [DELAY_W-1:0] later_dly;
        logic [TIME_W-1:0]  base;
        int                 count;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset configuration: threshold edge and zero delay.
        set_pacing(36, 80);
        send_button_sample(2'd0, 4'd0, 8'd0, 48'd0);
        send_button_sample(2'd0, 4'd0, 8'd31, 48'd1);
        send_button_sample(2'd0, 4'd0, 8'd30, 48'd2);
        send_button_sample(2'd0, 4'd0, 8'd31, 48'd3);
        send_button_sample(2'd0, 4'd0, 8'd31, 48'd3);
        send_button_sample(2'd3, 4'd15, 8'd255, 48'd100);
        send_button_sample(2'd3, 4'd15, 8'd255, 48'd100);
        send_button_sample(2'd3, 4'd15, 8'd200, 48'd101);
        send_button_sample(2'd3, 4'd15, 8'd0, 48'd102);

        // Longest delays near the end of time: due times saturate.
        apply_config(8'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        send_button_sample(2'd1, 4'd5, 8'd1, TIME_MAX - 2);
        send_button_sample(2'd1, 4'd5, 8'd255, TIME_MAX - 1);
        send_button_sample(2'd1, 4'd5, 8'd1, TIME_MAX);
        send_button_sample(2'd1, 4'd5, 8'd128, TIME_MAX);
        send_button_sample(2'd1, 4'd5, 8'd0, TIME_MAX);
        send_button_sample(2'd2, 4'd10, 8'd1, 48'd0);
        send_button_sample(2'd2, 4'd10, 8'd85, 48'h00_00FF_FFFE);
        send_button_sample(2'd2, 4'd10, 8'd170, 48'h00_00FF_FFFF);

        // A write to the spare index changes nothing; a full threshold blocks presses.
        wait_drained();
        write_reg(CFG_IDX_SPARE, 24'hAB_CDEF);
        write_reg(CFG_PRESS_THRESHOLD, CFG_DATA_W'(8'hFF));
        send_button_sample(2'd1, 4'd6, 8'd255, TIME_MAX);
        send_button_sample(2'd2, 4'd10, 8'd0, TIME_MAX);

        // Random phases, each with its own configuration and pacing.
        for (int seg = 0; seg < 7; seg++) begin
            base = TIME_W'({$urandom, $urandom});
            count = 300;
            case (seg)
                0: begin thr = 8'd30; first_dly = '0; later_dly = '0; base = '0; count = 250; end
                1: begin thr = 8'd0; first_dly = 24'd3; later_dly = 24'd2; count = 250; end
                2: begin thr = 8'hFF; first_dly = '0; later_dly = '0; count = 50; end
                3: begin
                    thr = 8'd128;
                    first_dly = 24'hFF_FFFF;
                    later_dly = 24'hFF_FFFF;
                    base = TIME_MAX - 2000;
                    count = 150;
                end
                6: begin
                    thr = AMT_W'($urandom_range(1, 254));
                    first_dly = DELAY_W'($urandom_range(0, 16));
                    later_dly = '0;
                end
                default: begin
                    thr = AMT_W'($urandom_range(1, 254));
                    first_dly = DELAY_W'($urandom_range(0, 8));
                    later_dly = DELAY_W'($urandom_range(0, 4));
                end
            endcase
            apply_config(thr, first_dly, later_dly);
            case (seg % 3)
                0: set_pacing(36, 80);
                1: set_pacing(80, 36);
                default: set_pacing(0, 0);
            endcase
            // Hold the result side off for a while so the block backs up into its input.
            if (seg == 1 || seg == 5)
                hold_requests++;
            if (seg == 4) begin
                run_random_presses(count / 2, base, thr);
                wait_drained();
                run_random_presses(count - count / 2, base + 48'd5000, thr);
            end else begin
                run_random_presses(count, base, thr);
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("button_press_repeat_detector_top_tb: done, clean");
        else
            $display("button_press_repeat_detector_top_tb: done, errors");
        $finish;
    end

endmodule
